>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on clk, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on clk that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cfdf_pkg.sv
// ----------------------------------------------------------------------------
// cfdf_pkg
// Types and constants shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package cfdf_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Largest decoded frame kept in bytes
  localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 8'd255;

  localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_FULL  = 8'hFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RCPT_OFS   = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] NODE_ADDR_RST  = 8'd0;
  localparam logic [BYTE_W-1:0] BCAST_ADDR_RST = 8'd255;
  localparam logic [BYTE_W-1:0] RCPT_OFS_RST   = 8'd0;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_SHORT     = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] node_address;
    logic [BYTE_W-1:0] broadcast_address;
    logic [LEN_W-1:0]  recipient_offset;
  } cfg_t;

  typedef struct packed {
    logic              item_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              for_this_node;
    logic [1:0]        frame_status;
  } result_t;

endpackage

>>> sv/cfdf_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfdf_cfg_regs
// Configuration register file: node, broadcast address and recipient offset.
// ----------------------------------------------------------------------------
module cfdf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cfdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfdf_pkg::BYTE_W-1:0]  cfg_data,
  output cfdf_pkg::cfg_t               cfg
);
  import cfdf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE_ADDR:  cfg_nxt.node_address      = cfg_data;
        CFG_BCAST_ADDR: cfg_nxt.broadcast_address = cfg_data;
        CFG_RCPT_OFS:   cfg_nxt.recipient_offset  = cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address      <= NODE_ADDR_RST;
      cfg_r.broadcast_address <= BCAST_ADDR_RST;
      cfg_r.recipient_offset  <= RCPT_OFS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/cfdf_decode.sv
// ----------------------------------------------------------------------------
// cfdf_decode
// Frame state registers and one-byte COBS decode step.
// ----------------------------------------------------------------------------
module cfdf_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [cfdf_pkg::BYTE_W-1:0] link_byte,
  input  cfdf_pkg::cfg_t              cfg,
  output logic                        res_valid,
  output cfdf_pkg::result_t           res
);
  import cfdf_pkg::*;

  logic [BYTE_W-1:0] group_remaining_r, group_remaining_nxt;
  logic              prev_full_r, prev_full_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [LEN_W-1:0]  bytes_kept_r, bytes_kept_nxt;
  logic [BYTE_W-1:0] captured_r, captured_nxt;
  logic              seen_r, seen_nxt;
  logic              ovf_r, ovf_nxt;

  logic              keep;
  logic [BYTE_W-1:0] keep_byte;
  logic              mine;

  assign mine = seen_r && ((captured_r == cfg.node_address) ||
                           (captured_r == cfg.broadcast_address));

  always_comb begin
    group_remaining_nxt = group_remaining_r;
    prev_full_nxt       = prev_full_r;
    awaiting_nxt        = awaiting_r;
    bytes_kept_nxt      = bytes_kept_r;
    captured_nxt        = captured_r;
    seen_nxt            = seen_r;
    ovf_nxt             = ovf_r;
    keep                = 1'b0;
    keep_byte           = link_byte;
    res_valid           = 1'b0;
    res                 = '0;

    if (link_byte == DELIM_BYTE) begin
      res_valid          = 1'b1;
      res.item_kind      = KIND_END;
      res.frame_length   = bytes_kept_r;
      res.for_this_node  = mine;
      priority if (ovf_r)                                  res.frame_status = ST_OVERFLOW;
      else if (!awaiting_r && group_remaining_r != '0)     res.frame_status = ST_TRUNCATED;
      else if (!seen_r)                                    res.frame_status = ST_SHORT;
      else                                                 res.frame_status = ST_OK;
      // clear frame state
      group_remaining_nxt = '0;
      prev_full_nxt       = 1'b0;
      awaiting_nxt        = 1'b1;
      bytes_kept_nxt      = '0;
      captured_nxt        = '0;
      seen_nxt            = 1'b0;
      ovf_nxt             = 1'b0;
    end else if (awaiting_r || group_remaining_r == '0) begin
      // code byte: open a group, restore a zero after a short group
      awaiting_nxt        = 1'b0;
      group_remaining_nxt = link_byte - BYTE_W'(1);
      prev_full_nxt       = (link_byte == CODE_FULL);
      keep                = !awaiting_r && !prev_full_r;
      keep_byte           = '0;
    end else begin
      group_remaining_nxt = group_remaining_r - BYTE_W'(1);
      keep                = 1'b1;
    end

    if (keep) begin
      if (bytes_kept_r >= MAX_FRAME_BYTES) begin
        ovf_nxt = 1'b1;
      end else begin
        if (bytes_kept_r == cfg.recipient_offset) begin
          captured_nxt = keep_byte;
          seen_nxt     = 1'b1;
        end
        bytes_kept_nxt = bytes_kept_r + LEN_W'(1);
        res_valid      = 1'b1;
        res.item_kind  = KIND_DATA;
        res.data_byte  = keep_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_remaining_r <= '0;
      prev_full_r       <= 1'b0;
      awaiting_r        <= 1'b1;
      bytes_kept_r      <= '0;
      captured_r        <= '0;
      seen_r            <= 1'b0;
      ovf_r             <= 1'b0;
    end else if (accept) begin
      group_remaining_r <= group_remaining_nxt;
      prev_full_r       <= prev_full_nxt;
      awaiting_r        <= awaiting_nxt;
      bytes_kept_r      <= bytes_kept_nxt;
      captured_r        <= captured_nxt;
      seen_r            <= seen_nxt;
      ovf_r             <= ovf_nxt;
    end
  end

endmodule

>>> sv/cfdf_out_buf.sv
// ----------------------------------------------------------------------------
// cfdf_out_buf
// Result register with a one-entry skid stage behind it.
// ----------------------------------------------------------------------------
module cfdf_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  cfdf_pkg::result_t res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output cfdf_pkg::result_t out_res
);
  import cfdf_pkg::*;

  logic    out_valid_r;
  result_t out_res_r;
  logic    skid_valid_r;
  result_t skid_res_r;
  logic    out_take;

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no new transaction while the skid entry waits
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_valid_r || out_take) begin
      out_res_r <= res;
    end else if (res_valid) begin
      skid_res_r <= res;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> sv/cobs_frame_decoder_filter.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder_filter
// COBS frame decoder with frame-end report and recipient address filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_link_byte) carries one encoded
//   link byte per transaction; 0x00 is the frame delimiter.
//   Result channel (out_valid / out_stall / out_*) carries either a decoded
//   data byte (out_item_kind = 0) or a frame-end report (out_item_kind = 1)
//   with length, status and the recipient match flag. A code byte that
//   restores no zero gives no result.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes node address, broadcast address and recipient offset; it is
//   always ready. Write it only while no frame traffic is in flight.
// Timing:
//   An accepted input transaction's result is registered in the output stages.
//   Throughput is one byte per cycle while in_stall is low: the decode step
//   is a single pass of logic from frame state to the result register.
// Stall:
//   A result that is held by out_stall stays in the output register and the
//   next result lands in a one-entry skid stage; in_stall rises only while
//   that skid entry is occupied.
// Reset:
//   rst_n (synchronous) restores register defaults, empties the output
//   stages and returns the decoder to awaiting the first code of a frame.
// ----------------------------------------------------------------------------
module cobs_frame_decoder_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cfdf_pkg::BYTE_W-1:0]    in_link_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_item_kind,
  output logic [cfdf_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [cfdf_pkg::LEN_W-1:0]     out_frame_length,
  output logic                           out_for_this_node,
  output logic [1:0]                     out_frame_status,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfdf_pkg::BYTE_W-1:0]    cfg_data
);
  import cfdf_pkg::*;

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  result_t out_res;

  // advance decoder state only on an accepted transaction
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  cfdf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfdf_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .link_byte (in_link_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold results across receiver stalls
  cfdf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid && in_accept),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_item_kind     = out_res.item_kind;
  assign out_data_byte     = out_res.data_byte;
  assign out_frame_length  = out_res.frame_length;
  assign out_for_this_node = out_res.for_this_node;
  assign out_frame_status  = out_res.frame_status;

endmodule

>>> sv/cfdf_checker.sv
// ----------------------------------------------------------------------------
// cfdf_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfdf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_item_kind,
  input logic [cfdf_pkg::BYTE_W-1:0] out_data_byte,
  input logic [cfdf_pkg::LEN_W-1:0]  out_frame_length,
  input logic                        out_for_this_node,
  input logic [1:0]                  out_frame_status
);
  import cfdf_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

  `ASSERT_CLK(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_item_kind) && $stable(out_data_byte) && $stable(out_frame_length) && $stable(out_frame_status), "stalled result changed")

  `ASSERT_CLK(a_data_clean, out_valid && out_item_kind == KIND_DATA |-> out_frame_length == '0 && !out_for_this_node && out_frame_status == ST_OK, "data item carries report fields")

  `ASSERT_CLK(a_short_no_match, out_valid && out_item_kind == KIND_END && out_frame_status == ST_SHORT |-> !out_for_this_node, "recipient match without a captured recipient")

  `ASSERT_CLK(a_ok_nonempty, out_valid && out_item_kind == KIND_END && out_frame_status == ST_OK |-> out_frame_length != '0 && out_data_byte == '0, "ok report with empty frame")

endmodule

bind cobs_frame_decoder_filter cfdf_checker u_cfdf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_item_kind     (out_item_kind),
  .out_data_byte     (out_data_byte),
  .out_frame_length  (out_frame_length),
  .out_for_this_node (out_for_this_node),
  .out_frame_status  (out_frame_status)
);
